[rtl/text_line_number_escape_filter_defines.svh]
// ----------------------------------------------------------------------------
// Text line filter assertion macros
// Shared assertion forms; each expects clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_NUMBER_ESCAPE_FILTER_DEFINES_SVH
`define TEXT_LINE_NUMBER_ESCAPE_FILTER_DEFINES_SVH

// The condition must never hold outside reset.
`define TLNEF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define TLNEF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/tlnef_pkg.sv]
// ----------------------------------------------------------------------------
// Text line filter package
// Shared types, codes and byte helpers for the front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlnef_pkg;

  // Width of the printed line number column.
  localparam int NUMBER_DIGITS = 6;

  // Longest segment: a number or blank column (digits plus tab), or an
  // escaped character of up to four bytes.
  localparam int SEG_MAX = (NUMBER_DIGITS + 1 > 4) ? NUMBER_DIGITS + 1 : 4;
  localparam int POS_W   = $clog2(SEG_MAX);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINT  = 3'd5;

  // Output segments of one word, in emission order.
  localparam int NUM_SEGS  = 8;
  localparam int SEG_IDX_W = 3;
  localparam logic [SEG_IDX_W-1:0] SEG_NUM1  = 3'd0;  // number before a blank line
  localparam logic [SEG_IDX_W-1:0] SEG_FCOL  = 3'd1;  // blank column of a flushed line
  localparam logic [SEG_IDX_W-1:0] SEG_FDOL  = 3'd2;  // dollar of a flushed line
  localparam logic [SEG_IDX_W-1:0] SEG_FNL   = 3'd3;  // newline of a flushed line
  localparam logic [SEG_IDX_W-1:0] SEG_NUM2  = 3'd4;  // number at a line start
  localparam logic [SEG_IDX_W-1:0] SEG_BCOL  = 3'd5;  // blank column of an empty line
  localparam logic [SEG_IDX_W-1:0] SEG_DOL   = 3'd6;  // dollar before a newline
  localparam logic [SEG_IDX_W-1:0] SEG_CHAR  = 3'd7;  // the byte itself, maybe escaped

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_META_LO = 8'h80;
  localparam logic [7:0] CH_META_HI = 8'hA0;
  localparam logic [7:0] CH_CTRL_HI = 8'h20;
  localparam logic [7:0] CARET_OFS = 8'h40;

  // Line counter as packed decimal, element 0 is the least significant digit.
  typedef logic [NUMBER_DIGITS-1:0][3:0] digits_t;
  localparam digits_t COUNT_ONE = digits_t'(1);

  // One word of work handed from the front end to the back end.
  typedef struct packed {
    logic [NUM_SEGS-1:0] segs;
    digits_t             num1;
    digits_t             num2;
    logic [3:0][7:0]     chars;    // chars[0] goes out first
    logic [1:0]          ch_last;  // index of the last character byte
  } job_t;

  // Saturating decimal increment: all nines stays all nines.
  function automatic digits_t count_inc(digits_t v);
    digits_t r;
    logic    carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (v[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i]  = v[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return carry ? v : r;
  endfunction

  // Byte at a position of the number column: digits with leading spaces,
  // then a tab.
  function automatic logic [7:0] number_byte(digits_t v, logic [POS_W-1:0] pos);
    logic [7:0] b;
    logic       lead;
    b    = CH_TAB;
    lead = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      lead = lead && (v[NUMBER_DIGITS-1-i] == 4'd0) && (i != NUMBER_DIGITS - 1);
      if (pos == POS_W'(i)) begin
        b = lead ? CH_SPACE : {4'h3, v[NUMBER_DIGITS-1-i]};
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/text_line_number_escape_filter.sv]
// A word accepted at the input is written into the queue; its first output byte then enters the
// output register, from which the consumer takes it when out_tready is high.
// Throughput: one output byte per cycle while the queue holds work and out_tready is high; a word
// causes 1 to 27 output bytes. Words that cause no bytes are accepted and do not reach the output.
// The output sequencer sets the rate: one byte per cycle into one output register unless stalled.
// Reset (rst_n low, synchronous) clears configuration, line state and the work queue.
// ----------------------------------------------------------------------------
// Text line filter top level
// Line numbering, line end marks, blank run squeezing and caret escaping of a
// byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_line_number_escape_filter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic                             cfg_wdata,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  wire logic                             in_tuser,   // [0] kind
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [7:0]                       out_tdata,  // [7:0] out_byte
  output      logic                             out_tlast
);
  import tlnef_pkg::*;

  job_t push_job, head_job;
  logic push, full, pop, head_valid;

  tlnef_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  tlnef_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  tlnef_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/tlnef_front.sv]
// ----------------------------------------------------------------------------
// Text line filter front end
// Holds configuration and line state, classifies each input word and builds
// the list of output segments it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlnef_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic                             cfg_wdata,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [7:0]                       in_tdata,
  input  wire logic                             in_tuser,
  input  wire logic                             q_full,
  output      logic                             q_push,
  output      tlnef_pkg::job_t                  q_job
);
  import tlnef_pkg::*;

  logic    all_r, nonblank_r, ends_r, squeeze_r, tabs_r, nonprint_r;
  logic    inside_r, inside_nxt;
  logic    pending_r, pending_nxt;
  digits_t cnt_r, cnt_nxt;

  logic accept, eos, nl, empty, start, squeezed, flush;
  logic [7:0] c;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign eos       = in_tuser;
  assign c         = in_tdata;
  assign nl        = (c == CH_NL);
  assign empty     = !inside_r && nl;
  assign start     = !inside_r && !nl;
  assign squeezed  = !eos && squeeze_r && empty;
  assign flush     = pending_r && (eos || (!squeezed && start));

  // Segment list and character expansion for this word.
  always_comb begin
    q_job         = '0;
    q_job.segs[SEG_NUM1] = (!eos && !squeezed && all_r && empty) || (flush && all_r);
    q_job.segs[SEG_FCOL] = flush && ends_r && nonblank_r;
    q_job.segs[SEG_FDOL] = flush && ends_r;
    q_job.segs[SEG_FNL]  = flush;
    q_job.segs[SEG_NUM2] = !eos && start && (nonblank_r || all_r);
    q_job.segs[SEG_BCOL] = !eos && !squeezed && empty && nonblank_r && ends_r;
    q_job.segs[SEG_DOL]  = !eos && !squeezed && nl && ends_r;
    q_job.segs[SEG_CHAR] = !eos && !squeezed;
    q_job.num1 = cnt_r;
    q_job.num2 = q_job.segs[SEG_NUM1] ? count_inc(cnt_r) : cnt_r;

    q_job.chars[0] = c;
    q_job.ch_last  = 2'd0;
    if (tabs_r && c == CH_TAB) begin
      q_job.chars[0] = CH_CARET;
      q_job.chars[1] = CH_I;
      q_job.ch_last  = 2'd1;
    end else if (nonprint_r && c == CH_DEL) begin
      q_job.chars[0] = CH_CARET;
      q_job.chars[1] = CH_QMARK;
      q_job.ch_last  = 2'd1;
    end else if (nonprint_r && c >= CH_META_LO && c < CH_META_HI) begin
      q_job.chars[0] = CH_M;
      q_job.chars[1] = CH_DASH;
      q_job.chars[2] = CH_CARET;
      q_job.chars[3] = c - CARET_OFS;
      q_job.ch_last  = 2'd3;
    end else if (nonprint_r && c < CH_CTRL_HI && c != CH_TAB && c != CH_NL) begin
      q_job.chars[0] = CH_CARET;
      q_job.chars[1] = c + CARET_OFS;
      q_job.ch_last  = 2'd1;
    end
  end

  assign q_push = accept && (q_job.segs != '0);

  // Next line state.
  always_comb begin
    inside_nxt  = inside_r;
    pending_nxt = pending_r;
    cnt_nxt     = cnt_r;
    if (eos) begin
      inside_nxt  = 1'b0;
      pending_nxt = 1'b0;
      cnt_nxt     = COUNT_ONE;
    end else if (squeezed) begin
      pending_nxt = 1'b1;
    end else begin
      inside_nxt = !nl;
      if (flush) begin
        pending_nxt = 1'b0;
      end
      if (q_job.segs[SEG_NUM2]) begin
        cnt_nxt = count_inc(q_job.num2);
      end else if (q_job.segs[SEG_NUM1]) begin
        cnt_nxt = count_inc(cnt_r);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_r      <= 1'b0;
      nonblank_r <= 1'b0;
      ends_r     <= 1'b0;
      squeeze_r  <= 1'b0;
      tabs_r     <= 1'b0;
      nonprint_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUMBER_ALL:      all_r      <= cfg_wdata;
        CFG_NUMBER_NONBLANK: nonblank_r <= cfg_wdata;
        CFG_SHOW_ENDS:       ends_r     <= cfg_wdata;
        CFG_SQUEEZE:         squeeze_r  <= cfg_wdata;
        CFG_SHOW_TABS:       tabs_r     <= cfg_wdata;
        CFG_SHOW_NONPRINT:   nonprint_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r  <= 1'b0;
      pending_r <= 1'b0;
      cnt_r     <= COUNT_ONE;
    end else if (accept) begin
      inside_r  <= inside_nxt;
      pending_r <= pending_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/tlnef_queue.sv]
// ----------------------------------------------------------------------------
// Text line filter work queue
// Two-entry queue of work words between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlnef_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tlnef_pkg::job_t push_job,
  output      logic            full,
  input  wire logic            pop,
  output      logic            head_valid,
  output      tlnef_pkg::job_t head_job
);
  import tlnef_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/tlnef_back.sv]
// ----------------------------------------------------------------------------
// Text line filter back end
// Walks the segments of the head work word and sends one byte per cycle
// through the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_line_number_escape_filter_defines.svh"

module tlnef_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire tlnef_pkg::job_t head_job,
  output      logic            pop,
  output      logic            out_tvalid,
  input  wire logic            out_tready,
  output      logic [7:0]      out_tdata,
  output      logic            out_tlast
);
  import tlnef_pkg::*;

  logic [NUM_SEGS-1:0]  done_r, remaining, cur_bit, rem_after;
  logic [POS_W-1:0]     pos_r, last_pos;
  logic [SEG_IDX_W-1:0] seg_idx;
  logic [7:0]           seg_byte, out_tdata_r;
  logic                 out_tvalid_r, out_tlast_r;
  logic                 adv, seg_end, final_byte;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Lowest segment of the head word not yet sent.
  assign remaining = head_job.segs & ~done_r;
  always_comb begin
    seg_idx = '0;
    for (int i = NUM_SEGS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        seg_idx = SEG_IDX_W'(i);
      end
    end
  end
  assign cur_bit   = NUM_SEGS'(1) << seg_idx;
  assign rem_after = remaining & ~cur_bit;

  // Byte and length of the current segment.
  always_comb begin
    seg_byte = CH_NL;
    last_pos = '0;
    case (seg_idx)
      SEG_NUM1: begin
        seg_byte = number_byte(head_job.num1, pos_r);
        last_pos = POS_W'(NUMBER_DIGITS);
      end
      SEG_NUM2: begin
        seg_byte = number_byte(head_job.num2, pos_r);
        last_pos = POS_W'(NUMBER_DIGITS);
      end
      SEG_FCOL, SEG_BCOL: begin
        seg_byte = (pos_r == POS_W'(NUMBER_DIGITS)) ? CH_TAB : CH_SPACE;
        last_pos = POS_W'(NUMBER_DIGITS);
      end
      SEG_FDOL, SEG_DOL: seg_byte = CH_DOLLAR;
      SEG_FNL:           seg_byte = CH_NL;
      SEG_CHAR: begin
        seg_byte = head_job.chars[pos_r[1:0]];
        last_pos = POS_W'(head_job.ch_last);
      end
      default: seg_byte = CH_NL;
    endcase
  end

  assign adv        = head_valid && (!out_tvalid_r || out_tready);
  assign seg_end    = (pos_r == last_pos);
  assign final_byte = seg_end && (rem_after == '0);
  assign pop        = adv && final_byte;

  // Segment walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      pos_r  <= '0;
    end else if (adv) begin
      if (seg_end) begin
        pos_r  <= '0;
        done_r <= final_byte ? '0 : (done_r | cur_bit);
      end else begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= seg_byte;
      out_tlast_r <= final_byte;
    end
  end

  `TLNEF_ASSERT_IMPL(a_head_has_work, head_valid, remaining != '0, "queued word with no segments left")
  `TLNEF_ASSERT_IMPL(a_pos_in_segment, head_valid, pos_r <= last_pos, "segment position past its end")
  `TLNEF_ASSERT_NEVER(a_idle_clean, !head_valid && (done_r != '0 || pos_r != '0), "walk state left over")

endmodule

`default_nettype wire
